// ===== src/itp_pkg.sv =====
// package: types, constants and helpers for the timestamp parser
`timescale 1ns / 1ps
package itp_pkg;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_REPR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_FIXED   = 2'd0,
    PH_FRAC    = 2'd1,
    PH_TAILBAD = 2'd2,
    PH_ZONE    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_DAYS  = 3'd1,
    BK_MUL1  = 3'd2,
    BK_MUL2  = 3'd3,
    BK_SUM   = 3'd4,
    BK_OUT   = 3'd5
  } back_state_t;

  // everything the front end hands to the back end for one string
  typedef struct packed {
    logic        iso;
    logic [1:0]  early_status;  // status known at the front (format / range, or the whole result for plain numbers)
    logic        early_final;   // early_status is the result
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] fraction;
    logic [3:0]  fraction_count;
    logic        zone_ok;
    logic [63:0] plain_value;
  } job_t;

  localparam logic [63:0] PlainLimitDiv10 = 64'd922337203685477580;
  localparam logic signed [63:0] MaxEpochDays = 64'sd106751;
  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [29:0] NsPerSec = 30'd1000000000;

  function automatic logic [29:0] frac_scale(input logic [3:0] n);
    logic [29:0] s;
    case (n)
      4'd0: s = 30'd1000000000;
      4'd1: s = 30'd100000000;
      4'd2: s = 30'd10000000;
      4'd3: s = 30'd1000000;
      4'd4: s = 30'd100000;
      4'd5: s = 30'd10000;
      4'd6: s = 30'd1000;
      4'd7: s = 30'd100;
      4'd8: s = 30'd10;
      default: s = 30'd1;
    endcase
    return s;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ===== src/itp_if.sv =====
// valid/ready stream interfaces for input and result words
`timescale 1ns / 1ps
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_char;
  logic       last;
  modport source (output valid, character, has_char, last, input ready);
  modport sink (input valid, character, has_char, last, output ready);
endinterface

interface itp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] epoch_nanoseconds;
  modport source (output valid, status, epoch_nanoseconds, input ready);
  modport sink (input valid, status, epoch_nanoseconds, output ready);
endinterface

// ===== src/itp_front.sv =====
// front end: per-character accumulation and early checks
`timescale 1ns / 1ps
module itp_front
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_has_char,
  input  logic       in_last,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic [4:0]  char_index_r;
  phase_t      iso_phase_r;
  logic [13:0] year_r;
  logic [6:0]  month_r, day_r, hour_r, minute_r, second_r;
  logic [29:0] fraction_r;
  logic [3:0]  fcount_r;
  logic        iso_bad_r, date_mark_r, plain_ovf_r, plain_bad_r, any_char_r;
  logic [63:0] plain_r;

  logic [4:0]  char_index_nxt;
  phase_t      iso_phase_nxt;
  logic [13:0] year_nxt;
  logic [6:0]  month_nxt, day_nxt, hour_nxt, minute_nxt, second_nxt;
  logic [29:0] fraction_nxt;
  logic [3:0]  fcount_nxt;
  logic        iso_bad_nxt, date_mark_nxt, plain_ovf_nxt, plain_bad_nxt, any_char_nxt;
  logic [63:0] plain_nxt;

  logic        accept, dig, zone;
  logic [3:0]  d;
  logic        range_bad;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign dig      = is_digit(in_character);
  assign d        = in_character[3:0];
  assign zone     = (in_character == "Z") || (in_character == "z");

  always_comb begin
    char_index_nxt = char_index_r;
    iso_phase_nxt  = iso_phase_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    hour_nxt       = hour_r;
    minute_nxt     = minute_r;
    second_nxt     = second_r;
    fraction_nxt   = fraction_r;
    fcount_nxt     = fcount_r;
    iso_bad_nxt    = iso_bad_r;
    date_mark_nxt  = date_mark_r;
    plain_nxt      = plain_r;
    plain_ovf_nxt  = plain_ovf_r;
    plain_bad_nxt  = plain_bad_r;
    any_char_nxt   = any_char_r;
    if (in_has_char) begin
      any_char_nxt = 1'b1;
      if ((in_character == "T") || (in_character == "-")) date_mark_nxt = 1'b1;
      if ((iso_phase_r == PH_FIXED) && (char_index_r < 5'd19)) begin
        char_index_nxt = char_index_r + 5'd1;
        if ((char_index_r == 5'd4) || (char_index_r == 5'd7)) begin
          if (in_character != "-") iso_bad_nxt = 1'b1;
        end else if (char_index_r == 5'd10) begin
          if (in_character != "T") iso_bad_nxt = 1'b1;
        end else if ((char_index_r == 5'd13) || (char_index_r == 5'd16)) begin
          if (in_character != ":") iso_bad_nxt = 1'b1;
        end else if (!dig) begin
          iso_bad_nxt = 1'b1;
        end else if (char_index_r < 5'd4) begin
          year_nxt = 14'(year_r * 14'd10 + 14'(d));
        end else if (char_index_r < 5'd7) begin
          month_nxt = 7'(month_r * 7'd10 + 7'(d));
        end else if (char_index_r < 5'd10) begin
          day_nxt = 7'(day_r * 7'd10 + 7'(d));
        end else if (char_index_r < 5'd13) begin
          hour_nxt = 7'(hour_r * 7'd10 + 7'(d));
        end else if (char_index_r < 5'd16) begin
          minute_nxt = 7'(minute_r * 7'd10 + 7'(d));
        end else begin
          second_nxt = 7'(second_r * 7'd10 + 7'(d));
        end
      end else begin
        case (iso_phase_r)
          PH_FIXED: begin
            if (in_character == ".") iso_phase_nxt = PH_FRAC;
            else iso_phase_nxt = zone ? PH_ZONE : PH_TAILBAD;
          end
          PH_FRAC: begin
            if (dig) begin
              if (fcount_r < 4'd9) begin
                fraction_nxt = 30'(fraction_r * 30'd10 + 30'(d));
                fcount_nxt   = fcount_r + 4'd1;
              end
            end else if ((fcount_r != 4'd0) && zone) begin
              iso_phase_nxt = PH_ZONE;
            end else begin
              iso_phase_nxt = PH_TAILBAD;
            end
          end
          default: iso_phase_nxt = PH_TAILBAD;
        endcase
      end
      if (!dig) begin
        plain_bad_nxt = 1'b1;
      end else if (!plain_ovf_r) begin
        if ((plain_r > PlainLimitDiv10) || ((plain_r == PlainLimitDiv10) && (d > 4'd7)))
          plain_ovf_nxt = 1'b1;
        else
          plain_nxt = (plain_r << 3) + (plain_r << 1) + 64'(d);
      end
    end
  end

  // close of string: uses the updated accumulators
  assign range_bad = (month_nxt < 7'd1) || (month_nxt > 7'd12) || (day_nxt < 7'd1) ||
                     (day_nxt > 7'd31) || (hour_nxt > 7'd23) || (minute_nxt > 7'd59) ||
                     (second_nxt > 7'd60);

  always_comb begin
    job = '0;
    job.iso            = date_mark_nxt;
    job.year           = year_nxt;
    job.month          = month_nxt;
    job.day            = day_nxt;
    job.hour           = hour_nxt[4:0];
    job.minute         = minute_nxt[5:0];
    job.second         = second_nxt[5:0];
    job.fraction       = fraction_nxt;
    job.fraction_count = fcount_nxt;
    job.zone_ok        = (iso_phase_nxt == PH_ZONE);
    job.plain_value    = plain_nxt;
    if (date_mark_nxt) begin
      if (iso_bad_nxt || (char_index_nxt < 5'd19)) begin
        job.early_status = ST_FORMAT;
        job.early_final  = 1'b1;
      end else if (range_bad) begin
        job.early_status = ST_RANGE;
        job.early_final  = 1'b1;
      end
    end else begin
      job.early_final = 1'b1;
      if (!any_char_nxt || plain_bad_nxt) job.early_status = ST_FORMAT;
      else if (plain_ovf_nxt) job.early_status = ST_REPR;
      else job.early_status = ST_OK;
    end
  end

  assign job_valid = in_valid && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      char_index_r <= '0;
      iso_phase_r  <= PH_FIXED;
      year_r       <= '0;
      month_r      <= '0;
      day_r        <= '0;
      hour_r       <= '0;
      minute_r     <= '0;
      second_r     <= '0;
      fraction_r   <= '0;
      fcount_r     <= '0;
      iso_bad_r    <= 1'b0;
      date_mark_r  <= 1'b0;
      plain_r      <= '0;
      plain_ovf_r  <= 1'b0;
      plain_bad_r  <= 1'b0;
      any_char_r   <= 1'b0;
    end else if (accept) begin
      char_index_r <= char_index_nxt;
      iso_phase_r  <= iso_phase_nxt;
      year_r       <= year_nxt;
      month_r      <= month_nxt;
      day_r        <= day_nxt;
      hour_r       <= hour_nxt;
      minute_r     <= minute_nxt;
      second_r     <= second_nxt;
      fraction_r   <= fraction_nxt;
      fcount_r     <= fcount_nxt;
      iso_bad_r    <= iso_bad_nxt;
      date_mark_r  <= date_mark_nxt;
      plain_r      <= plain_nxt;
      plain_ovf_r  <= plain_ovf_nxt;
      plain_bad_r  <= plain_bad_nxt;
      any_char_r   <= any_char_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (char_index_r == 5'd0) && !date_mark_r && !any_char_r)
    else $error("front state not cleared after close");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fcount_r <= 4'd9) && (char_index_r <= 5'd19))
    else $error("front counter beyond its cap");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fcount_r != 4'd0) |-> (iso_phase_r != PH_FIXED))
    else $error("fraction digits outside fraction phase");

endmodule

// ===== src/itp_queue.sv =====
// short job queue between front and back
`timescale 1ns / 1ps
module itp_queue
  import itp_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t          mem_r [Depth];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   count_r;
  logic          push, pop;

  assign push_ready = (count_r != (AW+1)'(Depth));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == AW'(Depth - 1)) ? '0 : wptr_r + 1'b1;
      if (pop) rptr_r <= (rptr_r == AW'(Depth - 1)) ? '0 : rptr_r + 1'b1;
      count_r <= count_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(Depth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ===== src/itp_back.sv =====
// back end: civil date to days, nanosecond sum, overflow checks
`timescale 1ns / 1ps
module itp_back
  import itp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [63:0] out_epoch_nanoseconds
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic signed [24:0] days_r;
  logic signed [34:0] day_s_r;
  logic signed [63:0] day_ns_r;
  logic [47:0] tod_s_ns_r;   // whole seconds times 1e9
  logic [59:0] frac_ns_r;
  logic [1:0]  status_r;
  logic signed [63:0] value_r;

  logic               load, take;
  logic signed [15:0] y;
  logic [9:0]         y_div16;
  logic [15:0]        era_prod;
  logic [3:0]         mp;
  logic signed [15:0] era;
  logic [8:0]         yoe;
  logic [14:0]        yoe_prod;
  logic [2:0]         yoe_div100;
  logic [8:0]         doy_base;
  logic [8:0]         doy;
  logic [18:0]        doe;
  logic signed [24:0] days_c;
  logic [16:0]        secs;
  logic signed [64:0] sum65;
  logic [63:0]        tod;

  assign job_ready = (state_r == BK_IDLE);
  assign load      = job_valid && job_ready;
  assign out_valid = (state_r == BK_OUT);
  assign take      = out_valid && out_ready;
  assign out_status = status_r;
  assign out_epoch_nanoseconds = value_r;

  // days from civil, on the registered job
  // year is -1..9999, so era is -1..24; divisions by reciprocal multiply
  always_comb begin
    y   = (job_r.month <= 7'd2) ? 16'(signed'({2'b0, job_r.year})) - 16'sd1
                                : 16'(signed'({2'b0, job_r.year}));
    y_div16  = 10'(y >>> 4);
    era_prod = 16'(y_div16) * 16'd41;
    era = (y < 0) ? -16'sd1 : 16'(era_prod[15:10]);
    yoe = 9'(y - era * 16'sd400);
    yoe_prod   = 15'(yoe) * 15'd41;
    yoe_div100 = yoe_prod[14:12];
    mp  = (job_r.month > 7'd2) ? 4'(job_r.month - 7'd3) : 4'(job_r.month + 7'd9);
    case (mp)
      4'd0:  doy_base = 9'd0;
      4'd1:  doy_base = 9'd31;
      4'd2:  doy_base = 9'd61;
      4'd3:  doy_base = 9'd92;
      4'd4:  doy_base = 9'd122;
      4'd5:  doy_base = 9'd153;
      4'd6:  doy_base = 9'd184;
      4'd7:  doy_base = 9'd214;
      4'd8:  doy_base = 9'd245;
      4'd9:  doy_base = 9'd275;
      4'd10: doy_base = 9'd306;
      default: doy_base = 9'd337;
    endcase
    doy = 9'(doy_base + 9'(job_r.day) - 9'd1);
    doe = 19'(19'(yoe) * 19'd365 + 19'(yoe >> 2) - 19'(yoe_div100) + 19'(doy));
    days_c = 25'(era) * 25'sd146097 + 25'(signed'({1'b0, doe})) - 25'sd719468;
  end

  assign secs  = 17'(job_r.hour) * 17'd3600 + 17'(job_r.minute) * 17'd60
               + 17'(job_r.second);
  assign tod   = 64'(tod_s_ns_r) + 64'(frac_ns_r);
  assign sum65 = 65'(day_ns_r) + 65'(signed'({1'b0, tod}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (load) state_nxt = BK_DAYS;
      BK_DAYS: begin
        if (job_r.early_final) state_nxt = BK_OUT;
        else state_nxt = BK_MUL1;
      end
      BK_MUL1: state_nxt = BK_MUL2;
      BK_MUL2: state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_OUT;
      BK_OUT:  if (take) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= job;
    unique case (state_r)
      BK_DAYS: begin
        days_r   <= days_c;
        status_r <= job_r.early_status;
        value_r  <= (job_r.early_final && !job_r.iso && (job_r.early_status == ST_OK))
                    ? signed'(job_r.plain_value) : 64'sd0;
      end
      BK_MUL1: begin
        // only in-bound day counts are used, they fit 18 bits
        day_s_r    <= 35'(signed'(days_r[17:0])) * 35'(signed'({1'b0, SecPerDay}));
        tod_s_ns_r <= 48'(secs) * 48'(NsPerSec);
        frac_ns_r  <= 60'(job_r.fraction) * 60'(frac_scale(job_r.fraction_count));
        if ((days_r < -25'(MaxEpochDays)) || (days_r > 25'(MaxEpochDays)))
          status_r <= ST_REPR;
        else if (!job_r.zone_ok)
          status_r <= ST_FORMAT;
        else
          status_r <= ST_OK;
      end
      BK_MUL2: begin
        day_ns_r <= 64'(day_s_r) * 64'(signed'({1'b0, NsPerSec}));
      end
      BK_SUM: begin
        if ((status_r == ST_OK) && (sum65 > 65'sh0_7FFF_FFFF_FFFF_FFFF)) begin
          status_r <= ST_REPR;
          value_r  <= 64'sd0;
        end else if (status_r == ST_OK) begin
          value_r <= sum65[63:0];
        end else begin
          value_r <= 64'sd0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_epoch_nanoseconds == 64'sd0))
    else $error("nonzero value with error status");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == BK_DAYS))
    else $error("load did not start the back end");

endmodule

// ===== src/iso8601_timestamp_parser_unit.sv =====
// top level: iso 8601 timestamp string to signed epoch nanoseconds
// a closing word's job is queued, loaded into the back end and passes BK_DAYS to BK_OUT for
//   early-decided strings; full date strings also pass BK_MUL1, BK_MUL2 and BK_SUM
// throughput: one character word per cycle while the job queue has room; the back end takes
//   a new string only when idle; the two-entry job queue absorbs short strings behind a long one
// reset: synchronous active-low rst_n clears accumulators, queue and back-end state
`timescale 1ns / 1ps
module iso8601_timestamp_parser_unit
  import itp_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input logic clk,
  input logic rst_n,
  itp_in_if.sink    in_if,
  itp_out_if.source out_if
);

  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  job_t q_push_job, q_pop_job;

  itp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_character (in_if.character),
    .in_has_char  (in_if.has_char),
    .in_last      (in_if.last),
    .job_valid    (q_push_valid),
    .job_ready    (q_push_ready),
    .job          (q_push_job)
  );

  itp_queue #(.Depth(Depth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  itp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .job_valid             (q_pop_valid),
    .job_ready             (q_pop_ready),
    .job                   (q_pop_job),
    .out_valid             (out_if.valid),
    .out_ready             (out_if.ready),
    .out_status            (out_if.status),
    .out_epoch_nanoseconds (out_if.epoch_nanoseconds)
  );

endmodule

// ===== tb/iso8601_timestamp_parser_unit_tb.sv =====
// testbench: directed and random timestamp strings checked against a built-in parser model
`timescale 1ns / 1ps
module iso8601_timestamp_parser_unit_tb;
  import itp_pkg::*;

  localparam int WordLimit = 600;
  localparam int IdleLimit = 2000;
  localparam logic [63:0] DecimalCeilDiv10 = 64'd922337203685477580;
  localparam longint NsDay = 64'sd86400000000000;
  localparam longint NsSec = 64'sd1000000000;
  localparam longint DayBound = 64'sd106751;
  localparam longint I64Max = 64'sh7fffffffffffffff;
  localparam int DirCount = 26;

  typedef struct packed {
    status_t            st;
    logic signed [63:0] ns;
  } stamp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  iso8601_timestamp_parser_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser model state
  logic [4:0]  m_index;
  phase_t      m_phase;
  logic [13:0] m_year;
  logic [6:0]  m_month, m_day, m_hour, m_minute, m_second;
  logic [29:0] m_frac;
  logic [3:0]  m_frac_n;
  logic        m_iso_bad, m_date_mark;
  logic [63:0] m_plain;
  logic        m_plain_ovf, m_plain_bad, m_any;

  stamp_t pending_stamps[$];
  int errors = 0;
  int words_sent = 0;
  int strings_sent = 0;
  int stamps_seen = 0;
  int ok_seen = 0;
  int bad_seen = 0;
  int idle_cycles = 0;
  int out_stall = 0;
  bit quiet = 1'b0;

  task automatic clear_model();
    m_index = '0; m_phase = PH_FIXED;
    m_year = '0; m_month = '0; m_day = '0; m_hour = '0; m_minute = '0; m_second = '0;
    m_frac = '0; m_frac_n = '0; m_iso_bad = 1'b0; m_date_mark = 1'b0;
    m_plain = '0; m_plain_ovf = 1'b0; m_plain_bad = 1'b0; m_any = 1'b0;
  endtask

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic longint civil_day_count(longint y, longint mo, longint d);
    longint era, yoe, doy, doe;
    if (mo <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic stamp_t close_date();
    stamp_t r;
    longint days, day_ns, tod, scale;
    r.st = ST_OK;
    r.ns = '0;
    scale = 1;
    for (int k = m_frac_n; k < 9; k++) scale = scale * 10;
    if (m_iso_bad || m_index < 19) r.st = ST_FORMAT;
    else if (m_month < 1 || m_month > 12 || m_day < 1 || m_day > 31 || m_hour > 23 ||
             m_minute > 59 || m_second > 60) r.st = ST_RANGE;
    else begin
      days = civil_day_count(longint'(m_year), longint'(m_month), longint'(m_day));
      if (days < -DayBound || days > DayBound) r.st = ST_REPR;
      else if (m_phase != PH_ZONE) r.st = ST_FORMAT;
      else begin
        day_ns = days * NsDay;
        tod = (longint'(m_hour) * 3600 + longint'(m_minute) * 60 + longint'(m_second)) * NsSec
              + longint'(m_frac) * scale;
        if (day_ns > 0 && tod > I64Max - day_ns) r.st = ST_REPR;
        else r.ns = day_ns + tod;
      end
    end
    return r;
  endfunction

  task automatic fixed_char(logic [7:0] c);
    logic [6:0] d;
    d = 7'(c - "0");
    if (m_index == 4 || m_index == 7) begin
      if (c != "-") m_iso_bad = 1'b1;
    end else if (m_index == 10) begin
      if (c != "T") m_iso_bad = 1'b1;
    end else if (m_index == 13 || m_index == 16) begin
      if (c != ":") m_iso_bad = 1'b1;
    end else if (!digit(c)) begin
      m_iso_bad = 1'b1;
    end else if (m_index < 4) m_year = m_year * 10 + 14'(d);
    else if (m_index < 7) m_month = m_month * 10 + d;
    else if (m_index < 10) m_day = m_day * 10 + d;
    else if (m_index < 13) m_hour = m_hour * 10 + d;
    else if (m_index < 16) m_minute = m_minute * 10 + d;
    else m_second = m_second * 10 + d;
  endtask

  task automatic tail_of_date(logic [7:0] c);
    bit zone;
    zone = (c == "Z" || c == "z");
    if (m_phase == PH_FIXED) begin
      m_phase = (c == ".") ? PH_FRAC : (zone ? PH_ZONE : PH_TAILBAD);
    end else if (m_phase == PH_FRAC) begin
      if (digit(c)) begin
        if (m_frac_n < 9) begin
          m_frac = m_frac * 10 + 30'(c - "0");
          m_frac_n = m_frac_n + 1;
        end
      end else if (m_frac_n != 0 && zone) m_phase = PH_ZONE;
      else m_phase = PH_TAILBAD;
    end else begin
      m_phase = PH_TAILBAD;
    end
  endtask

  task automatic parse_word(logic [7:0] c, logic h, logic l);
    stamp_t r;
    if (h) begin
      m_any = 1'b1;
      if (c == "T" || c == "-") m_date_mark = 1'b1;
      if (m_phase == PH_FIXED && m_index < 19) begin
        fixed_char(c);
        m_index = m_index + 1;
      end else tail_of_date(c);
      if (!digit(c)) m_plain_bad = 1'b1;
      else if (!m_plain_ovf) begin
        if (m_plain > DecimalCeilDiv10 || (m_plain == DecimalCeilDiv10 && c > "7"))
          m_plain_ovf = 1'b1;
        else m_plain = m_plain * 10 + 64'(c - "0");
      end
    end
    if (l) begin
      r.st = ST_OK;
      r.ns = '0;
      if (m_date_mark) r = close_date();
      else if (!m_any || m_plain_bad) r.st = ST_FORMAT;
      else if (m_plain_ovf) r.st = ST_REPR;
      else r.ns = m_plain;
      if (r.st != ST_OK) r.ns = '0;
      pending_stamps.push_back(r);
      clear_model();
    end
  endtask

  task automatic put_word(logic [7:0] c, logic h, logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.character <= c;
    in_if.has_char <= h;
    in_if.last <= l;
    do @(posedge clk); while (!in_if.ready);
    parse_word(c, h, l);
    if (h || l) words_sent++;
    quiet = ((words_sent / 80) % 4) == 3;
  endtask

  task automatic send_text(byte unsigned txt[$], bit known, status_t st, longint ns);
    stamp_t r;
    bit split_close;
    split_close = txt.size() > 0 && $urandom_range(0, 9) == 0;
    if (txt.size() == 0) put_word(8'($urandom), 1'b0, 1'b1);
    foreach (txt[i]) begin
      if ($urandom_range(0, 19) == 0) put_word(8'($urandom), 1'b0, 1'b0);
      put_word(txt[i], 1'b1, i == txt.size() - 1 && !split_close);
    end
    if (split_close) put_word(8'($urandom), 1'b0, 1'b1);
    if (known) begin
      r.st = st;
      r.ns = ns;
      void'(pending_stamps.pop_back());
      pending_stamps.push_back(r);
    end
    strings_sent++;
  endtask

  function automatic void append_str(ref byte unsigned q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result side: random stall, check, watchdog
  always @(posedge clk) begin
    stamp_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (in_if.valid && in_if.ready) idle_cycles = 0;
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        stamps_seen++;
        if (pending_stamps.size() == 0) begin
          report($sformatf("unexpected word status %0d", out_if.status));
        end else begin
          want = pending_stamps.pop_front();
          if (want.st == ST_OK) ok_seen++;
          else bad_seen++;
          if (out_if.status !== want.st)
            report($sformatf("status %0d, want %0d", out_if.status, want.st));
          if (out_if.epoch_nanoseconds !== want.ns)
            report($sformatf("ns %0d, want %0d", out_if.epoch_nanoseconds, want.ns));
        end
        out_stall = quiet ? 0 : $urandom_range(0, 8);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_if.ready <= (out_stall == 0);
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
      end
    end
  end

  string dir_text[DirCount] = '{
    "1970-01-01T00:00:00Z", "0", "9223372036854775807", "9223372036854775808", "",
    "+5", "12a", "2262-04-11T23:47:16.854775807Z", "2262-04-11T23:47:16.854775808Z",
    "2262-04-12T00:00:00Z", "1677-09-21T00:12:43.145224192Z", "1970-13-01T00:00:00Z",
    "1970-01-32T00:00:00Z", "1970-01-01T24:00:00Z", "1970-01-01T00:60:00Z",
    "1970-01-01T00:00:60z", "1970-01-01T00:00:61Z", "1970-01-01", "1970/01-01T00:00:00Z",
    "1970-01-01T00:00:00.", "1970-01-01T00:00:00.Z", "1970-01-01T00:00:00",
    "1970-01-01T00:00:00Zx", "2000-02-29T12:34:56.1234567891234z", "9999-12-31T23:59:59Z",
    "1970-00-00T00:00:00Z"
  };
  bit dir_known[DirCount] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1,
                              1, 1, 1, 0, 1, 1};
  status_t dir_status[DirCount] = '{
    ST_OK, ST_OK, ST_OK, ST_REPR, ST_FORMAT, ST_FORMAT, ST_FORMAT, ST_OK, ST_OK, ST_REPR,
    ST_OK, ST_RANGE, ST_RANGE, ST_RANGE, ST_RANGE, ST_OK, ST_RANGE, ST_FORMAT, ST_FORMAT,
    ST_FORMAT, ST_FORMAT, ST_FORMAT, ST_FORMAT, ST_OK, ST_REPR, ST_RANGE
  };
  longint dir_ns[DirCount] = '{
    0, 0, I64Max, 0, 0, 0, 0, I64Max, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  initial begin
    byte unsigned txt[$];
    int kind, n, pos;
    clear_model();
    in_if.valid <= 1'b0;
    in_if.character <= '0;
    in_if.has_char <= 1'b0;
    in_if.last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirCount; i++) begin
      txt.delete();
      append_str(txt, dir_text[i]);
      send_text(txt, dir_known[i], dir_status[i], dir_ns[i]);
    end

    while (words_sent < WordLimit || strings_sent < 80) begin
      txt.delete();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        append_str(txt, $sformatf("%04d-%02d-%02dT%02d:%02d:%02d",
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 9999) : $urandom_range(1670, 2270),
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 12),
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 31),
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23),
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59),
          $urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 60)));
        n = $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 12);
        if (n >= 0) begin
          txt.push_back(".");
          repeat (n) txt.push_back(8'("0" + $urandom_range(0, 9)));
        end
        kind = $urandom_range(0, 19);
        if (kind < 9) txt.push_back("Z");
        else if (kind < 18) txt.push_back("z");
        else txt.push_back(8'($urandom));
        if ($urandom_range(0, 19) == 0) txt.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
          pos = $urandom_range(0, txt.size() - 1);
          if ($urandom_range(0, 1)) txt[pos] = 8'($urandom);
          else while (txt.size() > pos) void'(txt.pop_back());
        end
      end else if (kind < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          append_str(txt, "92233720368547758");
          n = 2;
        end else n = $urandom_range(1, 21);
        repeat (n) txt.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
      end else begin
        repeat ($urandom_range(0, 25)) txt.push_back(8'($urandom));
      end
      send_text(txt, 1'b0, ST_OK, 0);
    end
    in_if.valid <= 1'b0;

    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d strings in %0d words, %0d results (%0d ok, %0d rejected)",
             strings_sent, words_sent, stamps_seen, ok_seen, bad_seen);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
